[rtl/core/qrc_pkg.sv]
// qrc_pkg: shared widths, register indexes and the arctangent table for the
// quadrilateral rectangle check. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package qrc_pkg;

  localparam int CoordW   = 16;
  localparam int DiffW    = CoordW + 1;
  localparam int ProdW    = 2 * DiffW;
  localparam int SumW     = ProdW + 1;
  localparam int PreShift = 24;
  localparam int CordW    = SumW + PreShift + 3;
  localparam int AngW     = 27;
  localparam int AtanW    = 22;
  localparam int MaxIter  = 24;

  localparam int SideW    = 15;
  localparam int AngRegW  = 12;
  localparam int CfgAddrW = 2;
  localparam int CfgDataW = 15;

  localparam logic [CfgAddrW-1:0] REG_MIN_SIDE  = 2'd0;
  localparam logic [CfgAddrW-1:0] REG_MIN_ANGLE = 2'd1;
  localparam logic [CfgAddrW-1:0] REG_MAX_ANGLE = 2'd2;

  localparam logic signed [AngW-1:0] DEG180   = 27'sd11796480;
  localparam logic signed [AngW-1:0] HALF_DEG = 27'sd32768;

  // atan(2^-i) in units of 2^-16 degree
  function automatic logic [AtanW-1:0] atan_lut(input logic [4:0] i);
    logic [AtanW-1:0] r;
    case (i)
      5'd0:    r = 22'd2949120;
      5'd1:    r = 22'd1740967;
      5'd2:    r = 22'd919879;
      5'd3:    r = 22'd466945;
      5'd4:    r = 22'd234379;
      5'd5:    r = 22'd117304;
      5'd6:    r = 22'd58666;
      5'd7:    r = 22'd29335;
      5'd8:    r = 22'd14668;
      5'd9:    r = 22'd7334;
      5'd10:   r = 22'd3667;
      5'd11:   r = 22'd1833;
      5'd12:   r = 22'd917;
      5'd13:   r = 22'd458;
      5'd14:   r = 22'd229;
      5'd15:   r = 22'd115;
      5'd16:   r = 22'd57;
      5'd17:   r = 22'd29;
      5'd18:   r = 22'd14;
      5'd19:   r = 22'd7;
      5'd20:   r = 22'd4;
      5'd21:   r = 22'd2;
      5'd22:   r = 22'd1;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/core/qrc_lane.sv]
// qrc_lane: one corner lane, side length test plus pipelined vectoring cordic
// for the corner angle. Depends on qrc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qrc_lane
  import qrc_pkg::*;
#(
  parameter int ANGLE_ITERATIONS = 16
) (
  input  wire                         clk,
  input  wire  [ANGLE_ITERATIONS+3:0] en,
  input  wire  signed [CoordW-1:0]    ax,
  input  wire  signed [CoordW-1:0]    ay,
  input  wire  signed [CoordW-1:0]    bx,
  input  wire  signed [CoordW-1:0]    by,
  input  wire  signed [CoordW-1:0]    cx,
  input  wire  signed [CoordW-1:0]    cy,
  input  wire  [SideW-1:0]            min_side,
  input  wire  [AngRegW-1:0]          min_angle,
  input  wire  [AngRegW-1:0]          max_angle,
  output logic                        lane_ok
);

  localparam int N = ANGLE_ITERATIONS;

  logic signed [DiffW-1:0] ux_r, uy_r, vx_r, vy_r;
  logic signed [ProdW-1:0] pxx_r, pyy_r, pxy_r, pyx_r, sxx_r, syy_r;
  logic signed [SumW-1:0]  dot_r, crs_r;
  logic                    side2_r;
  logic [2*SideW-1:0]      msq;
  logic signed [CordW-1:0] x_r [N+1];
  logic signed [CordW-1:0] y_r [N+1];
  logic signed [AngW-1:0]  z_r [N+1];
  logic                    sok_r [N+1];
  logic signed [CordW-1:0] x0, y0;
  logic signed [AngW-1:0]  ze;
  logic [AngW-1:0]         zabs;
  logic [AngW-1:0]         lo, hi;

  assign msq = (2*SideW)'(min_side) * (2*SideW)'(min_side);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ux_r <= DiffW'(bx) - DiffW'(ax);
      uy_r <= DiffW'(by) - DiffW'(ay);
      vx_r <= DiffW'(bx) - DiffW'(cx);
      vy_r <= DiffW'(by) - DiffW'(cy);
    end
    if (en[1]) begin
      pxx_r <= ux_r * vx_r;
      pyy_r <= uy_r * vy_r;
      pxy_r <= ux_r * vy_r;
      pyx_r <= uy_r * vx_r;
      sxx_r <= ux_r * ux_r;
      syy_r <= uy_r * uy_r;
    end
    if (en[2]) begin
      dot_r   <= SumW'(pxx_r) + SumW'(pyy_r);
      crs_r   <= SumW'(pxy_r) - SumW'(pyx_r);
      side2_r <= (SumW'(sxx_r) + SumW'(syy_r)) >= $signed({5'b0, msq});
    end
  end

  // dot and cross scaled by 2^24 before the rotation
  assign x0 = {{(CordW-SumW-PreShift){dot_r[SumW-1]}}, dot_r, PreShift'(0)};
  assign y0 = {{(CordW-SumW-PreShift){crs_r[SumW-1]}}, crs_r, PreShift'(0)};

  always_ff @(posedge clk) begin
    if (en[3]) begin
      sok_r[0] <= side2_r;
      if (x0 < 0) begin
        x_r[0] <= -x0;
        y_r[0] <= -y0;
        z_r[0] <= (y0 >= 0) ? DEG180 : -DEG180;
      end else begin
        x_r[0] <= x0;
        y_r[0] <= y0;
        z_r[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    logic signed [CordW-1:0] xs, ys;
    logic signed [AngW-1:0]  at;
    assign xs = x_r[i] >>> i;
    assign ys = y_r[i] >>> i;
    assign at = AngW'(atan_lut(5'(i)));
    always_ff @(posedge clk) begin
      if (en[4+i]) begin
        sok_r[i+1] <= sok_r[i];
        if (y_r[i] > 0) begin
          x_r[i+1] <= x_r[i] + ys;
          y_r[i+1] <= y_r[i] - xs;
          z_r[i+1] <= z_r[i] + at;
        end else if (y_r[i] < 0) begin
          x_r[i+1] <= x_r[i] - ys;
          y_r[i+1] <= y_r[i] + xs;
          z_r[i+1] <= z_r[i] - at;
        end else begin
          x_r[i+1] <= x_r[i];
          y_r[i+1] <= y_r[i];
          z_r[i+1] <= z_r[i];
        end
      end
    end
  end

  assign ze   = z_r[N] + HALF_DEG;
  assign zabs = ze[AngW-1] ? AngW'(-ze) : AngW'(ze);
  assign lo   = AngW'({min_angle, 12'b0});
  assign hi   = AngW'({max_angle, 12'b0});

  assign lane_ok = sok_r[N] && (zabs >= lo) && (zabs <= hi);

endmodule
`default_nettype wire

[rtl/core/quad_rectangle_check.sv]
// quad_rectangle_check: top level, config registers, stage handshake and the
// merge of four corner lanes. Depends on qrc_pkg and qrc_lane.
//
//   channel  dir  width  contents
//   in_*     in   128    x0,y0,x1,y1,x2,y2,x3,y3 (16-bit signed each)
//   out_*    out  8      valid_res in bit 0
//   cfg_*    in   2/15   min_side, min_angle, max_angle writes
//
// one quadrilateral per cycle while the output is not stalled; the pipeline depth is
// set by the unrolled cordic stages in each lane.
// every stage has its own valid bit, so bubbles close up under a stalled output.
// synchronous active-low reset clears the valid bits and loads register defaults.
`timescale 1ns / 1ps
`default_nettype none
module quad_rectangle_check
  import qrc_pkg::*;
#(
  parameter int ANGLE_ITERATIONS = 16
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_tvalid,
  output logic                in_tready,
  input  wire  [127:0]        in_tdata,   // x0, y0, x1, y1, x2, y2, x3, y3
  output logic                out_tvalid,
  input  wire                 out_tready,
  output logic [7:0]          out_tdata,  // valid_res, zero pad
  input  wire                 cfg_we,
  input  wire  [CfgAddrW-1:0] cfg_addr,
  input  wire  [CfgDataW-1:0] cfg_wdata
);

  localparam int LS = ANGLE_ITERATIONS + 4;
  localparam int L  = LS + 1;

  logic [SideW-1:0]   min_side_r;
  logic [AngRegW-1:0] min_angle_r, max_angle_r;
  logic [L-1:0]       v_r;
  logic [L-1:0]       rdy;
  logic [3:0]         lane_ok;
  logic               res_r;
  logic signed [CoordW-1:0] px [4];
  logic signed [CoordW-1:0] py [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_side_r  <= 15'd160;
      min_angle_r <= 12'd1280;
      max_angle_r <= 12'd1600;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MIN_SIDE:  min_side_r  <= cfg_wdata;
        REG_MIN_ANGLE: min_angle_r <= cfg_wdata[AngRegW-1:0];
        REG_MAX_ANGLE: max_angle_r <= cfg_wdata[AngRegW-1:0];
        default: ;
      endcase
    end
  end

  // a stage moves when it is empty or the next one moves
  always_comb begin
    rdy[L-1] = !v_r[L-1] || out_tready;
    for (int s = L - 2; s >= 0; s--) rdy[s] = !v_r[s] || rdy[s+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_tvalid;
      for (int s = 1; s < L; s++) if (rdy[s]) v_r[s] <= v_r[s-1];
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_pt
    assign px[k] = in_tdata[32*k +: 16];
    assign py[k] = in_tdata[32*k + 16 +: 16];
  end

  // lane k: side p(k)p(k+1) and corner at p(k+1)
  for (genvar k = 0; k < 4; k++) begin : g_lane
    qrc_lane #(.ANGLE_ITERATIONS(ANGLE_ITERATIONS)) u_lane (
      .clk       (clk),
      .en        (rdy[LS-1:0]),
      .ax        (px[k]),
      .ay        (py[k]),
      .bx        (px[(k+1)%4]),
      .by        (py[(k+1)%4]),
      .cx        (px[(k+2)%4]),
      .cy        (py[(k+2)%4]),
      .min_side  (min_side_r),
      .min_angle (min_angle_r),
      .max_angle (max_angle_r),
      .lane_ok   (lane_ok[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rdy[L-1]) res_r <= &lane_ok;
  end

  assign in_tready  = rdy[0];
  assign out_tvalid = v_r[L-1];
  assign out_tdata  = {7'b0, res_r};

  a_bubble_takes_input: assert property (@(posedge clk) disable iff (!rst_n)
    !v_r[0] |-> in_tready) else $error("empty first stage refused input");

  a_reset_empties: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid) else $error("output valid right after reset");

  a_last_stage_fills: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[L-2] && rdy[L-1] |=> out_tvalid) else $error("result lost before output");

endmodule
`default_nettype wire

[dv/quad_rectangle_check_test.sv]
// quad_rectangle_check_test: self-checking bench for the quadrilateral
// rectangle check. Depends on qrc_pkg and the quad_rectangle_check rtl.
`timescale 1ns / 1ps
module quad_rectangle_check_test
  import qrc_pkg::*;
;

  localparam int NumSteps = 16;
  localparam int Latency  = NumSteps + 5;
  localparam logic [CfgAddrW-1:0] RegUnmapped = 2'd3;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [127:0]        in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [7:0]          out_tdata;
  logic                cfg_we = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  quad_rectangle_check #(.ANGLE_ITERATIONS(NumSteps)) dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .cfg_we, .cfg_addr, .cfg_wdata
  );

  always #6 clk = ~clk;

  // shadow registers
  logic [SideW-1:0]   side_min;
  logic [AngRegW-1:0] ang_lo;
  logic [AngRegW-1:0] ang_hi;

  logic verdict_q[$];
  int   send_idle_pct;
  int   recv_idle_pct;
  int   mismatches;
  int   quads_sent;
  int   passes_seen;

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  // |atan2(cross, dot) + half degree| in 2^-16 degree
  function automatic longint corner_deg(longint ax, longint ay, longint bx, longint by,
                                        longint cx, longint cy);
    longint ux, uy, vx, vy, x, y, z, xs, ys;
    ux = bx - ax; uy = by - ay;
    vx = bx - cx; vy = by - cy;
    x = (ux * vx + uy * vy) * (64'sd1 << PreShift);
    y = (ux * vy - uy * vx) * (64'sd1 << PreShift);
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? 180 * 65536 : -180 * 65536;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < NumSteps && i < MaxIter; i++) begin
      xs = floor_shr(x, i);
      ys = floor_shr(y, i);
      if (y > 0) begin
        x = x + ys; y = y - xs; z += longint'(atan_lut(i[4:0]));
      end else if (y < 0) begin
        x = x - ys; y = y + xs; z -= longint'(atan_lut(i[4:0]));
      end
    end
    z += 32768;
    return z < 0 ? -z : z;
  endfunction

  function automatic logic rectangle_verdict(logic [127:0] q);
    longint px[4], py[4];
    longint dx, dy, a, lo, hi;
    logic ok;
    ok = 1'b1;
    for (int k = 0; k < 4; k++) begin
      px[k] = longint'($signed(q[32*k +: 16]));
      py[k] = longint'($signed(q[32*k+16 +: 16]));
    end
    for (int k = 0; k < 4; k++) begin
      dx = px[k] - px[(k+1)%4];
      dy = py[k] - py[(k+1)%4];
      if (dx * dx + dy * dy < longint'(side_min) * longint'(side_min)) ok = 1'b0;
    end
    lo = longint'(ang_lo) << 12;
    hi = longint'(ang_hi) << 12;
    for (int k = 0; k < 4; k++) begin
      a = corner_deg(px[k], py[k], px[(k+1)%4], py[(k+1)%4], px[(k+2)%4], py[(k+2)%4]);
      if (a < lo || a > hi) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic logic [127:0] pack_quad(int xa, ya, xb, yb, xc, yc, xd, yd);
    return {yd[15:0], xd[15:0], yc[15:0], xc[15:0], yb[15:0], xb[15:0], ya[15:0], xa[15:0]};
  endfunction

  task automatic send_quad(logic [127:0] q);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= q;
    verdict_q.insert(verdict_q.size(), rectangle_verdict(q));
    quads_sent++;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_reg(logic [CfgAddrW-1:0] idx, int val);
    in_tvalid <= 1'b0;
    wait (verdict_q.size() == 0);
    repeat (Latency + 4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val[CfgDataW-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MIN_SIDE:  side_min = val[SideW-1:0];
      REG_MIN_ANGLE: ang_lo = val[AngRegW-1:0];
      REG_MAX_ANGLE: ang_hi = val[AngRegW-1:0];
      default: ;
    endcase
  endtask

  // receiver stall and result check
  always @(posedge clk) begin
    logic exp_v;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (out_tdata[0]) passes_seen++;
        if (verdict_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transfer: valid_res=%0b", out_tdata[0]);
        end else begin
          exp_v = verdict_q.pop_front();
          if (out_tdata[0] !== exp_v || out_tdata[7:1] !== 7'd0) begin
            mismatches++;
            if (mismatches <= 10)
              $display("valid_res mismatch: expected %0b got %0b (pad %h)",
                       exp_v, out_tdata[0], out_tdata[7:1]);
          end
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // rectangle-ish quad: center, half-sizes, jitter
  function automatic logic [127:0] near_rect(int cx, int cy, int hw, int hh, int jit);
    int j[8];
    foreach (j[i]) j[i] = (jit == 0) ? 0 : $urandom_range(2 * jit) - jit;
    return pack_quad(cx - hw + j[0], cy - hh + j[1], cx + hw + j[2], cy - hh + j[3],
                     cx + hw + j[4], cy + hh + j[5], cx - hw + j[6], cy + hh + j[7]);
  endfunction

  task automatic test_directed();
    send_quad(near_rect(0, 0, 160, 160, 0));
    send_quad(near_rect(0, 0, 80, 80, 0));
    send_quad(near_rect(0, 0, 79, 200, 0));
    send_quad('0);                                               // degenerate corners
    send_quad(pack_quad(0, 0, 400, 0, 800, 0, 400, 0));          // straight-back corners
    send_quad(pack_quad(-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767));
    send_quad(pack_quad(32767, 32767, -32768, 32767, -32768, -32768, 32767, -32768));
    send_quad(pack_quad(-32768, 0, 0, -32768, 32767, 0, 0, 32767));
    send_quad(pack_quad(0, 0, 1000, 0, 1200, 800, 200, 800));    // parallelogram
    send_quad(pack_quad(0, 0, 1000, 0, 0, 1000, 1000, 1000));    // crossed
    send_quad(near_rect(100, -50, 300, 150, 0));
    send_quad({8{16'hFFFF}});
    send_quad({8{16'h8000}});
    send_quad({4{16'h7FFF, 16'h8000}});
  endtask

  task automatic test_window_edges();
    write_reg(REG_MIN_SIDE, 0);
    write_reg(REG_MIN_ANGLE, 0);
    write_reg(REG_MAX_ANGLE, 2888);
    send_quad('0);
    send_quad(pack_quad(0, 0, 400, 0, 800, 0, 400, 0));
    send_quad(pack_quad(0, 0, 1000, 0, 0, 1000, 1000, 1000));
    write_reg(REG_MIN_SIDE, 32767);
    send_quad(pack_quad(-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767));
    write_reg(REG_MIN_SIDE, 160);
    write_reg(REG_MIN_ANGLE, 1600);                             // inverted window
    write_reg(REG_MAX_ANGLE, 1280);
    send_quad(near_rect(0, 0, 200, 200, 0));
    write_reg(REG_MIN_ANGLE, 1448);
    write_reg(REG_MAX_ANGLE, 1448);
    send_quad(near_rect(0, 0, 200, 200, 0));
    write_reg(RegUnmapped, 4095);
    send_quad(near_rect(0, 0, 200, 200, 0));
  endtask

  task automatic test_random(int count);
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(9);
      if (r < 6)
        send_quad(near_rect($urandom_range(4000) - 2000, $urandom_range(4000) - 2000,
                            $urandom_range(2000), $urandom_range(2000), $urandom_range(40)));
      else if (r < 9)
        send_quad({$urandom, $urandom, $urandom, $urandom});
      else
        send_quad(near_rect(0, 0, $urandom_range(32767), $urandom_range(32767), 0));
    end
  endtask

  task automatic set_window(int side, int lo, int hi);
    write_reg(REG_MIN_SIDE, side);
    write_reg(REG_MIN_ANGLE, lo);
    write_reg(REG_MAX_ANGLE, hi);
  endtask

  initial begin
    side_min = 15'd160; ang_lo = 12'd1280; ang_hi = 12'd1600;
    mismatches = 0; quads_sent = 0; passes_seen = 0;
    send_idle_pct = 26; recv_idle_pct = 81;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_window_edges();
    set_window(160, 1280, 1600);
    test_random(380);
    send_idle_pct = 81; recv_idle_pct = 26;
    set_window(1000, 1400, 1480);
    test_random(380);
    send_idle_pct = 0; recv_idle_pct = 0;
    set_window($urandom_range(32767), $urandom_range(2888), $urandom_range(2888));
    test_random(200);
    set_window(40, 1000, 1900);
    test_random(160);
    in_tvalid <= 1'b0;
    wait (verdict_q.size() == 0);
    repeat (Latency + 10) @(posedge clk);
    $display("ran %0d quadrilaterals over several side/angle windows, %0d judged rectangles",
             quads_sent, passes_seen);
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("quad_rectangle_check_test: done, clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("quad_rectangle_check_test: done, errors");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("quad_rectangle_check_test: done, errors");
    $finish;
  end

endmodule
